/* src/lpcc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lpcc_pkg;

  // default build parameters
  localparam int DEF_IMG_WIDTH   = 512;
  localparam int DEF_IMG_HEIGHT  = 512;
  localparam int DEF_NUM_CAMERAS = 4;
  localparam int DEF_COEF_BITS   = 32;

  // coefficients per camera and their slots
  localparam int TERMS   = 18;
  localparam int K_FX    = 12;
  localparam int K_FY    = 13;
  localparam int K_CX    = 14;
  localparam int K_CY    = 15;
  localparam int K_TX    = 16;
  localparam int K_TY    = 17;

  // projection divider: magnitude of the numerator and the positive depth
  localparam int DIV_BITS     = 63;
  localparam int DIV_DEN_BITS = 31;

  // operation codes on the input tuser
  localparam logic [1:0] OP_LOAD_PIXEL = 2'd0;
  localparam logic [1:0] OP_LOAD_COEF  = 2'd1;
  localparam logic [1:0] OP_POINT      = 2'd2;

  // configuration register indexes and reset values
  localparam logic       CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic       CFG_IMAGE_HEIGHT = 1'b1;
  localparam logic [9:0] CFG_DIM_RESET    = 10'd512;

  // default colour, packed red:green:blue
  localparam logic [23:0] COLOR_GREEN = 24'h00FF00;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_COEF,
    KIND_POINT
  } item_kind_e;

  // one classified item waiting for the back end
  typedef struct packed {
    item_kind_e         kind;
    logic [1:0]         cam;
    logic [8:0]         row;
    logic [8:0]         col;
    logic [23:0]        rgb;
    logic [4:0]         idx;
    logic signed [31:0] value;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } queue_item_t;

endpackage
`default_nettype wire

/* src/lpcc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module lpcc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* src/lpcc_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module lpcc_front
  import lpcc_pkg::*;
#(
  parameter int IMG_WIDTH   = DEF_IMG_WIDTH,
  parameter int IMG_HEIGHT  = DEF_IMG_HEIGHT,
  parameter int NUM_CAMERAS = DEF_NUM_CAMERAS,
  parameter int COEF_BITS   = DEF_COEF_BITS
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [183:0] s_axis_tdata_i,
  input  wire logic [1:0]   s_axis_tuser_i,
  output logic              q_valid_o,
  output queue_item_t       q_item_o,
  input  wire logic         q_pop_i
);

  localparam int CW = (COEF_BITS < 32) ? COEF_BITS : 32;

  queue_item_t item;
  logic        keep;
  logic        push;

  queue_item_t fifo_q [4];
  logic [1:0]  wr_q, rd_q;
  logic [2:0]  cnt_q;

  // unpack and classify; out-of-range loads and unused codes are dropped
  always_comb begin
    item.cam   = s_axis_tdata_i[1:0];
    item.row   = s_axis_tdata_i[10:2];
    item.col   = s_axis_tdata_i[19:11];
    item.rgb   = {s_axis_tdata_i[43:36], s_axis_tdata_i[35:28], s_axis_tdata_i[27:20]};
    item.idx   = s_axis_tdata_i[48:44];
    item.value = 32'(signed'(s_axis_tdata_i[49 +: CW]));
    item.x     = s_axis_tdata_i[112:81];
    item.y     = s_axis_tdata_i[144:113];
    item.z     = s_axis_tdata_i[176:145];
    item.kind  = KIND_POINT;
    keep       = 1'b0;
    case (s_axis_tuser_i)
      OP_LOAD_PIXEL: begin
        item.kind = KIND_PIXEL;
        keep = (32'(item.cam) < NUM_CAMERAS) && (32'(item.row) < IMG_HEIGHT) &&
               (32'(item.col) < IMG_WIDTH);
      end
      OP_LOAD_COEF: begin
        item.kind = KIND_COEF;
        keep = (32'(item.cam) < NUM_CAMERAS) && (32'(item.idx) < TERMS);
      end
      OP_POINT: begin
        item.kind = KIND_POINT;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign s_axis_tready_o = !cnt_q[2];
  assign push            = s_axis_tvalid_i && s_axis_tready_o && keep;

  // four-entry queue to the back end
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 2'd1;
      if (q_pop_i) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(push) - 3'(q_pop_i);
    end
  end

  assign q_valid_o = (cnt_q != 3'd0);
  assign q_item_o  = fifo_q[rd_q];

endmodule
`default_nettype wire

/* src/lpcc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// unsigned restoring divider, one quotient bit per stage
module lpcc_div #(
  parameter int N     = 63,
  parameter int M     = 31,
  parameter int AUX_W = 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [N-1:0]     dvd_i,
  input  wire logic [M-1:0]     den_i,
  input  wire logic [AUX_W-1:0] aux_i,
  output logic      [N-1:0]     quo_o,
  output logic      [AUX_W-1:0] aux_o
);

  logic [M-1:0]     rem_q [N];
  logic [N-1:0]     dq_q  [N];
  logic [M-1:0]     den_q [N];
  logic [AUX_W-1:0] aux_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [M-1:0]     rem_p;
    logic [N-1:0]     dq_p;
    logic [M-1:0]     den_p;
    logic [AUX_W-1:0] aux_p;
    logic [M:0]       trial;

    if (i == 0) begin : g_first
      assign rem_p = '0;
      assign dq_p  = dvd_i;
      assign den_p = den_i;
      assign aux_p = aux_i;
    end else begin : g_next
      assign rem_p = rem_q[i-1];
      assign dq_p  = dq_q[i-1];
      assign den_p = den_q[i-1];
      assign aux_p = aux_q[i-1];
    end

    assign trial = {rem_p, dq_p[N-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (trial >= {1'b0, den_p}) begin
          rem_q[i] <= M'(trial - {1'b0, den_p});
          dq_q[i]  <= {dq_p[N-2:0], 1'b1};
        end else begin
          rem_q[i] <= trial[M-1:0];
          dq_q[i]  <= {dq_p[N-2:0], 1'b0};
        end
        den_q[i] <= den_p;
        aux_q[i] <= aux_p;
      end
    end
  end

  assign quo_o = dq_q[N-1];
  assign aux_o = aux_q[N-1];

endmodule
`default_nettype wire

/* src/lpcc_cam.sv */
`timescale 1ns / 1ps
`default_nettype none
// one camera lane: transform, project, bound check
module lpcc_cam
  import lpcc_pkg::*;
#(
  parameter int IMG_WIDTH  = DEF_IMG_WIDTH,
  parameter int IMG_HEIGHT = DEF_IMG_HEIGHT
) (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [31:0]                k_i [TERMS],
  input  wire logic signed [31:0]                px_i,
  input  wire logic signed [31:0]                py_i,
  input  wire logic signed [31:0]                pz_i,
  input  wire logic [$clog2(IMG_WIDTH+1)-1:0]    wlim_i,
  input  wire logic [$clog2(IMG_HEIGHT+1)-1:0]   hlim_i,
  output logic                                   seen_o,
  output logic [$clog2(IMG_HEIGHT)-1:0]          row_o,
  output logic [$clog2(IMG_WIDTH)-1:0]           col_o
);

  localparam int RW = $clog2(IMG_HEIGHT);
  localparam int CL = $clog2(IMG_WIDTH);

  logic signed [31:0] p [3];
  logic signed [63:0] m_q [9];
  logic signed [63:0] acc [3];
  logic signed [31:0] q_q [3];
  logic signed [63:0] pu_q, pv_q;
  logic signed [31:0] d_q;
  logic signed [63:0] nu, nv;
  logic [DIV_BITS-1:0] mag_u, mag_v, quo_u, quo_v;
  logic               pos;
  logic [1:0]         aux_u;
  logic               aux_v;
  logic [63:0]        uu, vv;

  assign p[0] = px_i;
  assign p[1] = py_i;
  assign p[2] = pz_i;

  // rotation products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          m_q[r*3+j] <= k_i[r*4+j] * p[j];
        end
      end
    end
  end

  // floor to Q16.16, add translation, saturate
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 64'(k_i[r*4+3]) + (m_q[r*3] >>> 16) + (m_q[r*3+1] >>> 16) +
               (m_q[r*3+2] >>> 16);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        if (acc[r] > 64'sd2147483647) q_q[r] <= 32'sh7FFFFFFF;
        else if (acc[r] < -64'sd2147483648) q_q[r] <= 32'sh80000000;
        else q_q[r] <= acc[r][31:0];
      end
    end
  end

  // focal products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pu_q <= k_i[K_FX] * q_q[0];
      pv_q <= k_i[K_FY] * q_q[1];
      d_q  <= q_q[2];
    end
  end

  // numerators as sign and magnitude
  always_comb begin
    nu    = pu_q + {{16{k_i[K_TX][31]}}, k_i[K_TX], 16'h0};
    nv    = pv_q + {{16{k_i[K_TY][31]}}, k_i[K_TY], 16'h0};
    mag_u = nu[63] ? DIV_BITS'(-nu) : nu[DIV_BITS-1:0];
    mag_v = nv[63] ? DIV_BITS'(-nv) : nv[DIV_BITS-1:0];
    pos   = !d_q[31] && (d_q != 32'sd0);
  end

  lpcc_div #(.N(DIV_BITS), .M(DIV_DEN_BITS), .AUX_W(2)) u_div_u (
    .clk_i (clk_i),
    .en_i  (en_i),
    .dvd_i (mag_u),
    .den_i (d_q[DIV_DEN_BITS-1:0]),
    .aux_i ({pos, nu[63]}),
    .quo_o (quo_u),
    .aux_o (aux_u)
  );

  lpcc_div #(.N(DIV_BITS), .M(DIV_DEN_BITS), .AUX_W(1)) u_div_v (
    .clk_i (clk_i),
    .en_i  (en_i),
    .dvd_i (mag_v),
    .den_i (d_q[DIV_DEN_BITS-1:0]),
    .aux_i (nv[63]),
    .quo_o (quo_v),
    .aux_o (aux_v)
  );

  // restore sign, add principal point
  always_comb begin
    uu = (aux_u[0] ? (~{1'b0, quo_u} + 64'd1) : {1'b0, quo_u}) +
         {{32{k_i[K_CX][31]}}, k_i[K_CX]};
    vv = (aux_v ? (~{1'b0, quo_v} + 64'd1) : {1'b0, quo_v}) +
         {{32{k_i[K_CY][31]}}, k_i[K_CY]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seen_o <= aux_u[1] && !uu[63] && (uu != 64'd0) && (uu < 64'({wlim_i, 16'h0})) &&
                !vv[63] && (vv != 64'd0) && (vv < 64'({hlim_i, 16'h0}));
      row_o  <= vv[16 +: RW];
      col_o  <= uu[16 +: CL];
    end
  end

endmodule
`default_nettype wire

/* src/lpcc_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module lpcc_back
  import lpcc_pkg::*;
#(
  parameter int IMG_WIDTH   = DEF_IMG_WIDTH,
  parameter int IMG_HEIGHT  = DEF_IMG_HEIGHT,
  parameter int NUM_CAMERAS = DEF_NUM_CAMERAS,
  parameter int SRC_W       = $clog2(DEF_NUM_CAMERAS + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [9:0]       cfg_data_i,
  input  wire logic             q_valid_i,
  input  wire queue_item_t      q_item_i,
  output logic                  q_pop_o,
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic [119:0]          m_axis_tdata_o,
  output logic [SRC_W-1:0]      m_axis_tuser_o
);

  localparam int LAT     = DIV_BITS + 4;
  localparam int PIX_PER = IMG_WIDTH * IMG_HEIGHT;
  localparam int DEPTH   = NUM_CAMERAS * PIX_PER;
  localparam int AW      = $clog2(DEPTH);
  localparam int WL      = $clog2(IMG_WIDTH + 1);
  localparam int HL      = $clog2(IMG_HEIGHT + 1);
  localparam int RW      = $clog2(IMG_HEIGHT);
  localparam int CL      = $clog2(IMG_WIDTH);
  localparam int CAM_W   = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;

  logic [9:0]         width_q, height_q;
  logic [WL-1:0]      wlim;
  logic [HL-1:0]      hlim;
  logic signed [31:0] coef_q [NUM_CAMERAS][TERMS];

  logic               en, empty, pop_point, pop_load;
  logic [LAT-1:0]     v_q;
  logic signed [31:0] x_q [LAT];
  logic signed [31:0] y_q [LAT];
  logic signed [31:0] z_q [LAT];

  logic [NUM_CAMERAS-1:0] seen;
  logic [RW-1:0]          row [NUM_CAMERAS];
  logic [CL-1:0]          col [NUM_CAMERAS];

  logic [SRC_W-1:0]   win;
  logic [AW-1:0]      raddr, waddr;
  logic               pix_we;
  logic [23:0]        rdata;

  logic               out_valid_q, hit_q;
  logic [SRC_W-1:0]   src_q;
  logic signed [31:0] ox_q, oy_q, oz_q;

  // image size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_DIM_RESET;
      height_q <= CFG_DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign wlim = (32'(width_q) > IMG_WIDTH) ? WL'(IMG_WIDTH) : WL'(width_q);
  assign hlim = (32'(height_q) > IMG_HEIGHT) ? HL'(IMG_HEIGHT) : HL'(height_q);

  // issue: points stream in, loads wait until no point is in flight
  assign en        = !out_valid_q || m_axis_tready_i;
  assign empty     = (v_q == '0);
  assign pop_point = q_valid_i && (q_item_i.kind == KIND_POINT) && en;
  assign pop_load  = q_valid_i && (q_item_i.kind != KIND_POINT) && empty;
  assign q_pop_o   = pop_point || pop_load;
  assign pix_we    = pop_load && (q_item_i.kind == KIND_PIXEL);
  assign waddr     = AW'(32'(q_item_i.cam) * PIX_PER + 32'(q_item_i.row) * IMG_WIDTH +
                         32'(q_item_i.col));

  // coefficient table
  always_ff @(posedge clk_i) begin
    if (pop_load && (q_item_i.kind == KIND_COEF)) begin
      coef_q[q_item_i.cam[CAM_W-1:0]][q_item_i.idx] <= q_item_i.value;
    end
  end

  // point tracking alongside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], pop_point};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0] <= q_item_i.x;
      y_q[0] <= q_item_i.y;
      z_q[0] <= q_item_i.z;
      for (int i = 1; i < LAT; i++) begin
        x_q[i] <= x_q[i-1];
        y_q[i] <= y_q[i-1];
        z_q[i] <= z_q[i-1];
      end
    end
  end

  for (genvar c = 0; c < NUM_CAMERAS; c++) begin : g_cam
    lpcc_cam #(.IMG_WIDTH(IMG_WIDTH), .IMG_HEIGHT(IMG_HEIGHT)) u_cam (
      .clk_i  (clk_i),
      .en_i   (en),
      .k_i    (coef_q[c]),
      .px_i   (q_item_i.x),
      .py_i   (q_item_i.y),
      .pz_i   (q_item_i.z),
      .wlim_i (wlim),
      .hlim_i (hlim),
      .seen_o (seen[c]),
      .row_o  (row[c]),
      .col_o  (col[c])
    );
  end

  // the last camera that sees the point wins
  always_comb begin
    win   = SRC_W'(NUM_CAMERAS);
    raddr = '0;
    for (int c = 0; c < NUM_CAMERAS; c++) begin
      if (seen[c]) begin
        win   = SRC_W'(c);
        raddr = AW'(c * PIX_PER + 32'(row[c]) * IMG_WIDTH + 32'(col[c]));
      end
    end
  end

  lpcc_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_pixels (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (waddr),
    .wdata_i (q_item_i.rgb),
    .re_i    (en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q  <= x_q[LAT-1];
      oy_q  <= y_q[LAT-1];
      oz_q  <= z_q[LAT-1];
      src_q <= win;
      hit_q <= (seen != '0);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(hit_q ? rdata : COLOR_GREEN), oz_q, oy_q, ox_q};
  assign m_axis_tuser_o  = src_q;

endmodule
`default_nettype wire

/* src/lidar_point_camera_colorizer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Colors lidar points from NUM_CAMERAS camera images. Load items (tuser 0 pixel,
// 1 coefficient) fill the image memory and the per-camera 3x4 extrinsics and
// pinhole terms; point items (tuser 2) return the point with the color of the
// last camera that sees it, or green with source NUM_CAMERAS. Points are taken
// one per cycle while m_axis_tready_i does not stall the pipeline; the projection
// divider resolves one quotient bit per stage in every camera lane. A load
// behind a point waits for the point pipeline to drain; loads behind loads go
// one per cycle. Image memory and coefficients are not cleared: load before use.
module lidar_point_camera_colorizer_top
  import lpcc_pkg::*;
#(
  parameter int IMG_WIDTH   = DEF_IMG_WIDTH,
  parameter int IMG_HEIGHT  = DEF_IMG_HEIGHT,
  parameter int NUM_CAMERAS = DEF_NUM_CAMERAS,
  parameter int COEF_BITS   = DEF_COEF_BITS,
  parameter int SRC_W       = $clog2(NUM_CAMERAS + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [9:0]        cfg_data_i,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // camera, pixel_row, pixel_col, blue_in, green_in, red_in, coef_index,
  // coef_value, point_x, point_y, point_z, zero fill
  input  wire logic [183:0]      s_axis_tdata_i,
  // operation
  input  wire logic [1:0]        s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  // out_x, out_y, out_z, blue_out, green_out, red_out
  output logic [119:0]           m_axis_tdata_o,
  // source_camera
  output logic [SRC_W-1:0]       m_axis_tuser_o
);

  logic        q_valid, q_pop;
  queue_item_t q_item;

  lpcc_front #(
    .IMG_WIDTH   (IMG_WIDTH),
    .IMG_HEIGHT  (IMG_HEIGHT),
    .NUM_CAMERAS (NUM_CAMERAS),
    .COEF_BITS   (COEF_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  lpcc_back #(
    .IMG_WIDTH   (IMG_WIDTH),
    .IMG_HEIGHT  (IMG_HEIGHT),
    .NUM_CAMERAS (NUM_CAMERAS),
    .SRC_W       (SRC_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
`default_nettype wire
